@@ hw/rtl/aaq_pkg.sv @@
package aaq_pkg;

  // Palette geometry
  localparam int PaletteMax  = 16;
  localparam int PaletteSizeDefault = 16;
  localparam int IdxW        = 4;
  localparam int Levels      = $clog2(PaletteMax);
  localparam int ChanW       = 8;
  localparam int DistW       = 10;
  localparam int ThreshW     = 10;
  localparam int AttrW       = 8;

  // Palette channel levels
  localparam logic [ChanW-1:0] LevelOff = 8'd0;
  localparam logic [ChanW-1:0] LevelLo  = 8'd85;
  localparam logic [ChanW-1:0] LevelHi  = 8'd170;
  localparam logic [ChanW-1:0] LevelMax = 8'd255;

  // Glyph codes
  localparam logic [ChanW-1:0] GlyphSpace = 8'd32;
  localparam logic [ChanW-1:0] GlyphHigh  = 8'd128;

  localparam logic [ThreshW-1:0] ThreshReset = 10'd10;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [DistW-1:0] distance;
  } near_t;

  // Cell after the palette search, before fix-up
  typedef struct packed {
    logic [ChanW-1:0] glyph;
    near_t            fg;
    near_t            bg;
    logic             row_start;
  } cell_t;

  // Finished result
  typedef struct packed {
    logic [ChanW-1:0] glyph;
    logic [AttrW-1:0] attr;
    logic             far_color;
  } result_t;

  // Fixed 16-color ANSI palette
  function automatic rgb_t palette_rgb(input logic [IdxW-1:0] idx);
    rgb_t c;
    unique case (idx)
      4'd0:  c = '{LevelOff, LevelOff, LevelOff};
      4'd1:  c = '{LevelHi,  LevelOff, LevelOff};
      4'd2:  c = '{LevelOff, LevelHi,  LevelOff};
      4'd3:  c = '{LevelHi,  LevelLo,  LevelOff};
      4'd4:  c = '{LevelOff, LevelOff, LevelHi};
      4'd5:  c = '{LevelHi,  LevelOff, LevelHi};
      4'd6:  c = '{LevelOff, LevelHi,  LevelHi};
      4'd7:  c = '{LevelHi,  LevelHi,  LevelHi};
      4'd8:  c = '{LevelLo,  LevelLo,  LevelLo};
      4'd9:  c = '{LevelMax, LevelLo,  LevelLo};
      4'd10: c = '{LevelLo,  LevelMax, LevelLo};
      4'd11: c = '{LevelMax, LevelMax, LevelLo};
      4'd12: c = '{LevelLo,  LevelLo,  LevelMax};
      4'd13: c = '{LevelMax, LevelLo,  LevelMax};
      4'd14: c = '{LevelLo,  LevelMax, LevelMax};
      default: c = '{LevelMax, LevelMax, LevelMax};
    endcase
    return c;
  endfunction

  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Sum of absolute channel differences to one palette entry
  function automatic logic [DistW-1:0] color_dist(input rgb_t c,
                                                  input logic [IdxW-1:0] idx);
    rgb_t p;
    p = palette_rgb(idx);
    return {2'b00, abs_diff(c.red, p.red)}
         + {2'b00, abs_diff(c.green, p.green)}
         + {2'b00, abs_diff(c.blue, p.blue)};
  endfunction

endpackage

@@ hw/rtl/ansi_attribute_quantizer.sv @@
// ANSI attribute quantizer: text cells in, glyph and attribute bytes out.
// Input stream carries one cell per request: tdata holds the glyph and the
// foreground and background RGB bytes, tuser marks the first cell of a row.
// Output stream carries the fixed-up glyph and the attribute byte (background
// index high nibble, foreground index low nibble); tuser flags a cell whose
// nearest palette color lies beyond the warn threshold.
// Throughput is one cell per clock while the receiver takes results. The
// registers are the input register, the palette search register (two compare
// trees over the palette) and the fix-up register. Only the 8-bit previous
// attribute feeds back, and it is updated as a cell enters the fix-up
// register. The threshold must be written through cfg_we_i/cfg_wdata_i only
// while the block is idle; the block does not enforce this. Reset empties all
// three stages, sets the threshold to 10 and the previous attribute to 0.
// When the receiver stalls, each stage keeps its cell; s_axis_tready drops
// once the input stage holds a cell and the fix-up result is not taken.
module ansi_attribute_quantizer #(
  parameter int PALETTE_SIZE = aaq_pkg::PaletteSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // glyph[7:0], fg_red[15:8], fg_green[23:16], fg_blue[31:24],
  // bg_red[39:32], bg_green[47:40], bg_blue[55:48]
  input  logic [55:0] s_axis_tdata,
  // row_start[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // glyph_out[7:0], attribute[15:8]
  output logic [15:0] m_axis_tdata,
  // far_color[0]
  output logic [0:0]  m_axis_tuser
);

  logic [aaq_pkg::ThreshW-1:0] thresh_q;

  logic             a_vld_q, a_rdy;
  logic [55:0]      a_data_q;
  logic             a_row_q;
  aaq_pkg::rgb_t    fg_rgb, bg_rgb;
  aaq_pkg::near_t   fg_near, bg_near;

  logic             b_vld_q, b_rdy;
  aaq_pkg::cell_t   b_cell_q;

  aaq_pkg::result_t res;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= aaq_pkg::ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // Input stage
  assign a_rdy         = !a_vld_q || b_rdy;
  assign s_axis_tready = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (a_rdy) begin
      a_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && s_axis_tvalid) begin
      a_data_q <= s_axis_tdata;
      a_row_q  <= s_axis_tuser[0];
    end
  end

  // Palette search for both colors
  assign fg_rgb = '{a_data_q[15:8], a_data_q[23:16], a_data_q[31:24]};
  assign bg_rgb = '{a_data_q[39:32], a_data_q[47:40], a_data_q[55:48]};

  aaq_nearest #(.PALETTE_SIZE(PALETTE_SIZE)) u_near_fg (
    .color_i (fg_rgb),
    .near_o  (fg_near)
  );

  aaq_nearest #(.PALETTE_SIZE(PALETTE_SIZE)) u_near_bg (
    .color_i (bg_rgb),
    .near_o  (bg_near)
  );

  // Search result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_rdy) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy && a_vld_q) begin
      b_cell_q.glyph     <= a_data_q[7:0];
      b_cell_q.fg        <= fg_near;
      b_cell_q.bg        <= bg_near;
      b_cell_q.row_start <= a_row_q;
    end
  end

  // Fix-up and output register
  aaq_fixup u_fixup (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .thresh_i     (thresh_q),
    .cell_valid_i (b_vld_q),
    .cell_ready_o (b_rdy),
    .cell_i       (b_cell_q),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {res.attr, res.glyph};
  assign m_axis_tuser = res.far_color;

endmodule

@@ hw/rtl/aaq_nearest.sv @@
module aaq_nearest #(
  parameter int PALETTE_SIZE = aaq_pkg::PaletteSizeDefault
) (
  input  aaq_pkg::rgb_t  color_i,
  output aaq_pkg::near_t near_o
);

  localparam int N = aaq_pkg::PaletteMax;
  localparam int L = aaq_pkg::Levels;

  logic [aaq_pkg::DistW-1:0] lvl_dist [L+1][N];
  logic [aaq_pkg::IdxW-1:0]  lvl_idx  [L+1][N];
  logic                      lvl_vld  [L+1][N];

  // Compare tree over the palette; lower index wins a tie
  always_comb begin
    for (int p = 0; p < N; p++) begin
      lvl_dist[0][p] = aaq_pkg::color_dist(color_i, aaq_pkg::IdxW'(p));
      lvl_idx[0][p]  = aaq_pkg::IdxW'(p);
      lvl_vld[0][p]  = (p < PALETTE_SIZE);
    end
    for (int l = 1; l <= L; l++) begin
      for (int k = 0; k < N; k++) begin
        lvl_dist[l][k] = '0;
        lvl_idx[l][k]  = '0;
        lvl_vld[l][k]  = 1'b0;
      end
      for (int k = 0; k < N / 2; k++) begin
        if (k < (N >> l)) begin
          if (lvl_vld[l-1][2*k+1] &&
              (!lvl_vld[l-1][2*k] || (lvl_dist[l-1][2*k+1] < lvl_dist[l-1][2*k]))) begin
            lvl_dist[l][k] = lvl_dist[l-1][2*k+1];
            lvl_idx[l][k]  = lvl_idx[l-1][2*k+1];
          end else begin
            lvl_dist[l][k] = lvl_dist[l-1][2*k];
            lvl_idx[l][k]  = lvl_idx[l-1][2*k];
          end
          lvl_vld[l][k] = lvl_vld[l-1][2*k] | lvl_vld[l-1][2*k+1];
        end
      end
    end
  end

  assign near_o.idx      = lvl_idx[L][0];
  assign near_o.distance = lvl_dist[L][0];

endmodule

@@ hw/rtl/aaq_fixup.sv @@
module aaq_fixup (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [aaq_pkg::ThreshW-1:0] thresh_i,
  input  logic                        cell_valid_i,
  output logic                        cell_ready_o,
  input  aaq_pkg::cell_t              cell_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output aaq_pkg::result_t            res_o
);

  logic                      res_vld_q;
  aaq_pkg::result_t          res_q, res_d;
  logic [aaq_pkg::AttrW-1:0] prev_attr_q;
  logic                      take;

  assign cell_ready_o = !res_vld_q || res_ready_i;
  assign take         = cell_valid_i && cell_ready_o;

  // Apply row fix-up against the previous final attribute
  always_comb begin
    res_d.glyph     = cell_i.glyph;
    res_d.attr      = {cell_i.bg.idx, cell_i.fg.idx};
    res_d.far_color = (cell_i.fg.distance > thresh_i) || (cell_i.bg.distance > thresh_i);
    if (!cell_i.row_start) begin
      if (cell_i.fg.idx == cell_i.bg.idx) begin
        res_d.glyph = aaq_pkg::GlyphSpace;
      end
      if ((res_d.glyph < aaq_pkg::GlyphSpace) || (res_d.glyph >= aaq_pkg::GlyphHigh)) begin
        res_d.attr = prev_attr_q;
      end else if (res_d.glyph == aaq_pkg::GlyphSpace) begin
        res_d.attr = {res_d.attr[7:4], prev_attr_q[3:0]};
      end
    end
  end

  // Hold result valid until the downstream takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q   <= 1'b0;
      prev_attr_q <= '0;
    end else begin
      if (cell_ready_o) begin
        res_vld_q <= cell_valid_i;
      end
      if (take) begin
        prev_attr_q <= res_d.attr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

@@ bench/aaq_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams of the quantizer, predicts each accepted cell and
// compares every returned result against the oldest prediction.
module aaq_checker #(
  parameter int PaletteSize = aaq_pkg::PaletteSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [55:0] s_tdata_i,
  input  logic [0:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  input  logic [0:0]  m_tuser_i,
  output int          pending_o,
  output int          errors_o,
  output int          far_count_o
);

  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] attr;
    logic       far_color;
  } cell_out_t;

  // ANSI palette, entry 0 in the lowest 24 bits, each entry {red, green, blue}
  localparam logic [16*24-1:0] PaletteRgb = {
    24'hFFFFFF, 24'h55FFFF, 24'hFF55FF, 24'h5555FF,
    24'hFFFF55, 24'h55FF55, 24'hFF5555, 24'h555555,
    24'hAAAAAA, 24'h00AAAA, 24'hAA00AA, 24'h0000AA,
    24'hAA5500, 24'h00AA00, 24'hAA0000, 24'h000000
  };

  cell_out_t                   expected_cells[$];
  logic [aaq_pkg::ThreshW-1:0] warn_level;
  logic [7:0]                  last_attr;
  int                          mismatches;
  int                          far_seen;

  // Nearest palette entry by sum of channel distances, lowest index on a tie
  function automatic logic [3:0] nearest_entry(input aaq_pkg::rgb_t c, output logic far);
    int            best;
    int            d;
    int            span;
    aaq_pkg::rgb_t p;
    logic [3:0]    idx;
    best = 1000;
    idx  = '0;
    span = (PaletteSize > 16) ? 16 : PaletteSize;
    for (int k = 0; k < span; k++) begin
      p = PaletteRgb[k*24 +: 24];
      d = ((c.red   >= p.red)   ? int'(c.red)   - int'(p.red)   : int'(p.red)   - int'(c.red))
        + ((c.green >= p.green) ? int'(c.green) - int'(p.green) : int'(p.green) - int'(c.green))
        + ((c.blue  >= p.blue)  ? int'(c.blue)  - int'(p.blue)  : int'(p.blue)  - int'(c.blue));
      if (d < best) begin
        best = d;
        idx  = k[3:0];
      end
    end
    far = (best > int'(warn_level));
    return idx;
  endfunction

  // Quantize one cell and apply the in-row fix-up against the last attribute
  function automatic cell_out_t quantize_cell(input logic [55:0] data, input logic row_start);
    aaq_pkg::rgb_t fg_c;
    aaq_pkg::rgb_t bg_c;
    logic [3:0]    fg_idx;
    logic [3:0]    bg_idx;
    logic          fg_far;
    logic          bg_far;
    cell_out_t     r;
    fg_c.red   = data[15:8];
    fg_c.green = data[23:16];
    fg_c.blue  = data[31:24];
    bg_c.red   = data[39:32];
    bg_c.green = data[47:40];
    bg_c.blue  = data[55:48];
    fg_idx = nearest_entry(fg_c, fg_far);
    bg_idx = nearest_entry(bg_c, bg_far);
    r.glyph     = data[7:0];
    r.attr      = {bg_idx, fg_idx};
    r.far_color = fg_far | bg_far;
    if (!row_start) begin
      // matching colors blank the glyph
      if (fg_idx == bg_idx) r.glyph = aaq_pkg::GlyphSpace;
      // control and high glyphs inherit the whole attribute
      if (r.glyph < aaq_pkg::GlyphSpace || r.glyph >= aaq_pkg::GlyphHigh) begin
        r.attr = last_attr;
      end else if (r.glyph == aaq_pkg::GlyphSpace) begin
        // a space keeps its background, takes the previous foreground
        r.attr = {r.attr[7:4], last_attr[3:0]};
      end
    end
    return r;
  endfunction

  // Track the threshold, predict requests, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    cell_out_t want;
    cell_out_t got;
    if (!rst_ni) begin
      expected_cells.delete();
      warn_level  = aaq_pkg::ThreshReset;
      last_attr   = '0;
      mismatches  = 0;
      far_seen    = 0;
      pending_o   <= 0;
      errors_o    <= 0;
      far_count_o <= 0;
    end else begin
      if (cfg_we_i) warn_level = cfg_wdata_i;

      if (m_tvalid_i && m_tready_i) begin
        got.glyph     = m_tdata_i[7:0];
        got.attr      = m_tdata_i[15:8];
        got.far_color = m_tuser_i[0];
        if (got.far_color) far_seen++;
        if (expected_cells.size() == 0) begin
          if (mismatches < 10)
            $display("[chk] %0t: result %h/%h/%b with nothing outstanding",
                     $realtime, got.glyph, got.attr, got.far_color);
          mismatches++;
        end else begin
          want = expected_cells.pop_front();
          if (got.glyph != want.glyph || got.attr != want.attr ||
              got.far_color != want.far_color) begin
            if (mismatches < 10)
              $display("[chk] %0t: glyph exp %h got %h, attr exp %h got %h, far exp %b got %b",
                       $realtime, want.glyph, got.glyph, want.attr, got.attr,
                       want.far_color, got.far_color);
            mismatches++;
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        want = quantize_cell(s_tdata_i, s_tuser_i[0]);
        last_attr = want.attr;
        expected_cells.push_back(want);
      end

      pending_o   <= expected_cells.size();
      errors_o    <= mismatches;
      far_count_o <= far_seen;
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [9:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  int pending_cells;
  int error_count;
  int far_results;

  // Traffic shaping controls, shared with the receiver process
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit stall_req = 1'b0;
  int cells_sent = 0;
  int settings_used = 0;

  ansi_attribute_quantizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  aaq_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .pending_o   (pending_cells),
    .errors_o    (error_count),
    .far_count_o (far_results)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop for a hung run
  initial begin
    #10_000_000;
    $display("ansi_attribute_quantizer: mismatch");
    $finish;
  end

  // Idle span: mostly none or short, now and then long
  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random ready pattern, plus one long hold-off on request
  initial begin
    int gap;
    @(posedge clk_i);
    forever begin
      if (stall_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        stall_req = 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        gap = rx_steady ? 0 : idle_span();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // Offer one cell, hold it until accepted, then maybe idle
  task automatic send_cell(input logic [7:0] glyph, input aaq_pkg::rgb_t fg,
                           input aaq_pkg::rgb_t bg, input logic row_start);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bg.blue, bg.green, bg.red, fg.blue, fg.green, fg.red, glyph};
    s_axis_tuser  <= row_start;
    do @(posedge clk_i); while (!s_axis_tready);
    cells_sent++;
    gap = tx_steady ? 0 : idle_span();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every request has its result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cells != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [9:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  // Channel value: exact palette level, level with noise, or anything
  function automatic logic [7:0] pick_channel();
    int mode;
    int v;
    logic [7:0] level;
    mode = $urandom_range(0, 9);
    case ($urandom_range(0, 3))
      0:       level = aaq_pkg::LevelOff;
      1:       level = aaq_pkg::LevelLo;
      2:       level = aaq_pkg::LevelHi;
      default: level = aaq_pkg::LevelMax;
    endcase
    if (mode < 3) return 8'($urandom_range(0, 255));
    if (mode < 6) return level;
    v = int'(level) + $urandom_range(0, 24) - 12;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic send_random_cell();
    logic [7:0]    glyph;
    aaq_pkg::rgb_t fg;
    aaq_pkg::rgb_t bg;
    logic          row_start;
    case ($urandom_range(0, 19))
      0, 1, 2: glyph = 8'($urandom_range(0, 31));
      3, 4, 5: glyph = aaq_pkg::GlyphSpace;
      6, 7, 8: glyph = 8'($urandom_range(128, 255));
      default: glyph = 8'($urandom_range(33, 127));
    endcase
    fg = '{pick_channel(), pick_channel(), pick_channel()};
    bg = '{pick_channel(), pick_channel(), pick_channel()};
    if ($urandom_range(0, 4) == 0) bg = fg;
    row_start = ($urandom_range(0, 11) == 0);
    send_cell(glyph, fg, bg, row_start);
  endtask

  // Stimulus and verdict
  initial begin
    aaq_pkg::rgb_t black;
    aaq_pkg::rgb_t white;
    aaq_pkg::rgb_t grey;
    aaq_pkg::rgb_t red_c;
    aaq_pkg::rgb_t green_c;
    aaq_pkg::rgb_t blue_c;
    aaq_pkg::rgb_t dgrey;
    aaq_pkg::rgb_t lred;
    aaq_pkg::rgb_t lgreen;
    aaq_pkg::rgb_t yellow;
    aaq_pkg::rgb_t lblue;
    aaq_pkg::rgb_t magenta;
    aaq_pkg::rgb_t lmagenta;
    aaq_pkg::rgb_t cyan;
    aaq_pkg::rgb_t lcyan;
    logic [9:0]    level;
    black    = '{aaq_pkg::LevelOff, aaq_pkg::LevelOff, aaq_pkg::LevelOff};
    white    = '{aaq_pkg::LevelMax, aaq_pkg::LevelMax, aaq_pkg::LevelMax};
    grey     = '{aaq_pkg::LevelHi, aaq_pkg::LevelHi, aaq_pkg::LevelHi};
    red_c    = '{aaq_pkg::LevelHi, aaq_pkg::LevelOff, aaq_pkg::LevelOff};
    green_c  = '{aaq_pkg::LevelOff, aaq_pkg::LevelHi, aaq_pkg::LevelOff};
    blue_c   = '{aaq_pkg::LevelOff, aaq_pkg::LevelOff, aaq_pkg::LevelHi};
    dgrey    = '{aaq_pkg::LevelLo, aaq_pkg::LevelLo, aaq_pkg::LevelLo};
    lred     = '{aaq_pkg::LevelMax, aaq_pkg::LevelLo, aaq_pkg::LevelLo};
    lgreen   = '{aaq_pkg::LevelLo, aaq_pkg::LevelMax, aaq_pkg::LevelLo};
    yellow   = '{aaq_pkg::LevelMax, aaq_pkg::LevelMax, aaq_pkg::LevelLo};
    lblue    = '{aaq_pkg::LevelLo, aaq_pkg::LevelLo, aaq_pkg::LevelMax};
    magenta  = '{aaq_pkg::LevelHi, aaq_pkg::LevelOff, aaq_pkg::LevelHi};
    lmagenta = '{aaq_pkg::LevelMax, aaq_pkg::LevelLo, aaq_pkg::LevelMax};
    cyan     = '{aaq_pkg::LevelOff, aaq_pkg::LevelHi, aaq_pkg::LevelHi};
    lcyan    = '{aaq_pkg::LevelLo, aaq_pkg::LevelMax, aaq_pkg::LevelMax};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first cell has no predecessor and a control glyph
    send_cell(8'h00, red_c, blue_c, 1'b0);
    send_cell(8'h41, white, black, 1'b1);
    // matching colors: blanked in a row, untouched at row start
    send_cell(8'h41, grey, grey, 1'b0);
    send_cell(8'h41, grey, grey, 1'b1);
    // glyph class boundaries
    send_cell(8'd31, white, dgrey, 1'b0);
    send_cell(aaq_pkg::GlyphSpace, green_c, white, 1'b0);
    send_cell(8'd127, lred, black, 1'b0);
    send_cell(aaq_pkg::GlyphHigh, white, cyan, 1'b0);
    send_cell(8'hFF, black, white, 1'b0);
    // tie between entries resolves to the lower index
    send_cell(8'h42, '{8'd85, 8'd0, 8'd0}, '{8'd0, 8'd85, 8'd0}, 1'b1);
    // threshold edge: distance 10 is near, 11 is far, mid grey is far
    send_cell(8'h43, '{8'd10, 8'd0, 8'd0}, white, 1'b0);
    send_cell(8'h44, '{8'd11, 8'd0, 8'd0}, white, 1'b0);
    send_cell(8'h45, black, '{8'd128, 8'd128, 8'd128}, 1'b0);
    // every palette entry, exact
    send_cell(8'h46, black, dgrey, 1'b1);
    send_cell(8'h47, red_c, lred, 1'b1);
    send_cell(8'h48, green_c, lgreen, 1'b1);
    send_cell(8'h49, '{aaq_pkg::LevelHi, aaq_pkg::LevelLo, aaq_pkg::LevelOff}, yellow, 1'b1);
    send_cell(8'h4A, blue_c, lblue, 1'b1);
    send_cell(8'h4B, magenta, lmagenta, 1'b1);
    send_cell(8'h4C, cyan, lcyan, 1'b1);
    send_cell(8'h4D, grey, white, 1'b1);

    // Random phases, each under its own threshold
    for (int phase = 0; phase < 8; phase++) begin
      drain_results();
      case (phase)
        0:       level = 10'd0;
        1:       level = 10'd765;
        2:       level = aaq_pkg::ThreshReset;
        default: level = 10'($urandom_range(0, 765));
      endcase
      write_threshold(level);
      tx_steady = (phase == 2 || phase == 3);
      rx_steady = (phase == 2);
      // long receiver hold-off while the sender keeps pushing
      if (phase == 3) stall_req = 1'b1;
      for (int n = 0; n < 250; n++) begin
        // sender pause until the pipe has fully emptied
        if (phase == 5 && n == 125) drain_results();
        send_random_cell();
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d cells under %0d threshold writes, from 0 to 765; %0d far results.",
             cells_sent, settings_used, far_results);
    $display("Included a 300-cycle output stall with back-pressure and a mid-stream drain.");
    if (error_count == 0 && pending_cells == 0) begin
      $display("ansi_attribute_quantizer: match");
    end else begin
      $display("ansi_attribute_quantizer: mismatch");
    end
    $finish;
  end

endmodule
